// ----- rtl/core/lph_pkg.sv -----
// shared types and constants for the linear-probing hash table
// holds field widths, status and command codes and the microcode word format
// no dependencies
package lph_pkg;

  // field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned SIZE_W   = 5;

  // table geometry: the size register can name at most 31 slots
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned MAX_SLOTS       = (1 << SIZE_W) - 1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // remainder unit: key padded to a whole number of digits
  localparam int unsigned MOD_DIGIT_W = 4;
  localparam int unsigned MOD_PAD_W   = 32;
  localparam int unsigned MOD_STEPS   = MOD_PAD_W / MOD_DIGIT_W;
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  // microcode step addresses
  localparam int unsigned UPC_W = 2;
  localparam logic [UPC_W-1:0] STEP_IDLE  = 2'd0;
  localparam logic [UPC_W-1:0] STEP_MOD   = 2'd1;
  localparam logic [UPC_W-1:0] STEP_READ  = 2'd2;
  localparam logic [UPC_W-1:0] STEP_CHECK = 2'd3;

  // datapath operation selected by a control word
  typedef enum logic [1:0] {
    DP_LOAD,
    DP_MOD,
    DP_READ,
    DP_CHECK
  } dp_op_e;

  // jump condition selected by a control word
  typedef enum logic [1:0] {
    JC_NEVER,
    JC_NO_START,
    JC_MOD_MORE,
    JC_PROBE_MORE
  } jump_cond_e;

  // one microcode word
  typedef struct packed {
    dp_op_e            op;
    jump_cond_e        cond;
    logic [UPC_W-1:0]  target;
    logic              last;
  } ctrl_word_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic mod_more;
    logic probe_more;
  } seq_cond_t;

endpackage

// ----- rtl/core/lph_ram.sv -----
// generic ram with one write port and one registered read port
// one write and one read address per cycle; depends on nothing
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lph_seq.sv -----
// microcode sequencer: step counter, control store and jump logic
// depends on lph_pkg for the control word format and step addresses
module lph_seq import lph_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_cond_t  cond_i,
  output ctrl_word_t ctrl_o,
  output logic       busy_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_word_t       word;
  logic             jump;

  // control store
  always_comb begin
    unique case (upc_q)
      STEP_IDLE:  word = '{op: DP_LOAD,  cond: JC_NO_START,   target: STEP_IDLE, last: 1'b0};
      STEP_MOD:   word = '{op: DP_MOD,   cond: JC_MOD_MORE,   target: STEP_MOD,  last: 1'b0};
      STEP_READ:  word = '{op: DP_READ,  cond: JC_NEVER,      target: STEP_IDLE, last: 1'b0};
      STEP_CHECK: word = '{op: DP_CHECK, cond: JC_PROBE_MORE, target: STEP_READ, last: 1'b1};
      default:    word = '{op: DP_LOAD,  cond: JC_NEVER,      target: STEP_IDLE, last: 1'b1};
    endcase
  end

  // jump condition select
  always_comb begin
    unique case (word.cond)
      JC_NEVER:      jump = 1'b0;
      JC_NO_START:   jump = !cond_i.start;
      JC_MOD_MORE:   jump = cond_i.mod_more;
      JC_PROBE_MORE: jump = cond_i.probe_more;
      default:       jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (jump) begin
      upc_d = word.target;
    end else if (word.last) begin
      upc_d = STEP_IDLE;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = word;
  assign busy_o = (upc_q != STEP_IDLE);

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// top level of the linear-probing hash table
// depends on lph_pkg, lph_seq (microcode control) and lph_ram (key store)
//
// Usage:
//   Commands enter on start/busy: a request is taken at a clock edge with
//   start high and busy low, carrying cmd_i (0 insert, 1 search) and key_i.
//   Exactly one result per command appears on status_o and slot_index_o for a
//   single cycle, marked by done_o; it must be taken in that cycle, there is
//   no back-pressure on the result side.
//   The table size register is written over cfg_valid_i/cfg_ready_o with
//   cfg_data_i; ready is high whenever no command is in flight.
//   Steps: the request is taken, then the remainder of the key by the table
//   size is formed (4 key bits per cycle), then each probe reads the key
//   store and compares, with up to table-size probes. The next request can
//   be taken in the cycle done_o is high.
//   Reset clears all slot valid bits at once, so the table starts empty and
//   the size register returns to 16. No clearing pass is needed.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    slot_index_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SIZE_W-1:0]   cfg_data_i
);

  // only the first slots up to the largest size are ever probed
  localparam int unsigned USED_DEPTH = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
  localparam int unsigned SLOT_W     = $clog2(USED_DEPTH);
  localparam logic [SIZE_W-1:0] USED_SIZE = SIZE_W'(USED_DEPTH);

  ctrl_word_t ctrl;
  seq_cond_t  cond;
  logic       seq_busy;

  logic [SIZE_W-1:0]    size_q;
  logic [SIZE_W-1:0]    n_q;
  logic [SIZE_W-1:0]    live_n;
  logic                 cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic [MOD_PAD_W-1:0] kshift_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [SIZE_W-1:0]    rem_q;
  logic [SIZE_W:0]      rem_acc;
  logic [SLOT_W-1:0]    pos_q;
  logic [SIZE_W-1:0]    pos_inc;
  logic [SIZE_W-1:0]    probes_q;
  logic [USED_DEPTH-1:0] valid_q;

  logic                 accept;
  logic                 slot_free;
  logic                 key_hit;
  logic                 last_probe;
  logic                 finish;
  logic                 wr_en;
  logic [STATUS_W-1:0]  fin_status;
  logic                 fin_has_slot;
  logic [KEY_W-1:0]     rd_key;

  logic                 done_q;
  logic [STATUS_W-1:0]  status_q;
  logic [IDX_W-1:0]     slot_q;

  // microcode control
  lph_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl),
    .busy_o (seq_busy)
  );

  assign busy        = seq_busy;
  assign cfg_ready_o = !seq_busy;
  assign accept      = (ctrl.op == DP_LOAD) && start;

  // table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // effective size: zero acts as one, clamp to the slots present
  always_comb begin
    live_n = size_q;
    if (live_n == '0) begin
      live_n = SIZE_W'(1);
    end
    if (live_n > USED_SIZE) begin
      live_n = USED_SIZE;
    end
  end

  // remainder step: one digit of the key per cycle
  always_comb begin
    rem_acc = {1'b0, rem_q};
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      rem_acc = {rem_acc[SIZE_W-1:0], kshift_q[MOD_PAD_W-1-i]};
      if (rem_acc >= {1'b0, n_q}) begin
        rem_acc = rem_acc - {1'b0, n_q};
      end
    end
  end

  // probe evaluation
  assign slot_free  = !valid_q[pos_q];
  assign key_hit    = (rd_key == key_q);
  assign last_probe = (probes_q == (n_q - SIZE_W'(1)));
  assign pos_inc    = SIZE_W'(pos_q) + SIZE_W'(1);

  always_comb begin
    finish       = 1'b0;
    fin_status   = ST_MISSING;
    fin_has_slot = 1'b0;
    if (cmd_q == CMD_INSERT) begin
      if (slot_free) begin
        finish       = 1'b1;
        fin_status   = ST_INSERTED;
        fin_has_slot = 1'b1;
      end else if (last_probe) begin
        finish     = 1'b1;
        fin_status = ST_FULL;
      end
    end else begin
      if (slot_free) begin
        finish     = 1'b1;
        fin_status = ST_MISSING;
      end else if (key_hit) begin
        finish       = 1'b1;
        fin_status   = ST_FOUND;
        fin_has_slot = 1'b1;
      end else if (last_probe) begin
        finish     = 1'b1;
        fin_status = ST_MISSING;
      end
    end
  end

  assign wr_en = (ctrl.op == DP_CHECK) && (cmd_q == CMD_INSERT) && slot_free;

  assign cond.start      = start;
  assign cond.mod_more   = (mod_cnt_q != MOD_CNT_W'(MOD_STEPS - 1));
  assign cond.probe_more = !finish;

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      DP_LOAD: begin
        if (accept) begin
          cmd_q     <= cmd_i;
          key_q     <= key_i;
          kshift_q  <= MOD_PAD_W'(key_i);
          n_q       <= live_n;
          rem_q     <= '0;
          mod_cnt_q <= '0;
        end
      end
      DP_MOD: begin
        kshift_q  <= kshift_q << MOD_DIGIT_W;
        rem_q     <= rem_acc[SIZE_W-1:0];
        mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
        pos_q     <= SLOT_W'(rem_acc);
        probes_q  <= '0;
      end
      DP_CHECK: begin
        if (!finish) begin
          pos_q    <= (pos_inc == n_q) ? '0 : SLOT_W'(pos_inc);
          probes_q <= probes_q + SIZE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[pos_q] <= 1'b1;
    end
  end

  // key store
  lph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (USED_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pos_q),
    .wdata_i (key_q),
    .raddr_i (pos_q),
    .rdata_o (rd_key)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ctrl.op == DP_CHECK) && finish;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if ((ctrl.op == DP_CHECK) && finish) begin
      status_q <= fin_status;
      slot_q   <= fin_has_slot ? IDX_W'(pos_q) : '0;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;

endmodule

// ----- sim/tb_linear_probe_hash_table.sv -----
`timescale 1ns / 100ps
// self-checking testbench for linear_probe_hash_table: insert and search
// requests checked against a shadow table. depends on lph_pkg and the rtl top
module tb_linear_probe_hash_table;
  import lph_pkg::*;

  localparam int unsigned DEPTH          = TABLE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 48;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned NUM_PHASES     = 13;
  localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic                cmd_i        = CMD_INSERT;
  logic [KEY_W-1:0]    key_i        = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    slot_index_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_data_i   = '0;

  // shadow copy of the table and its size register
  logic [SIZE_W-1:0] shadow_size = SIZE_RESET;
  logic [KEY_W-1:0]  slot_key  [DEPTH];
  logic              slot_used [DEPTH] = '{default: 1'b0};

  request_t     request_q[$];
  outcome_t     outcome_q[$];
  logic [KEY_W-1:0] inserted_keys[$];

  bit          req_taken    = 1'b0;
  bit          gaps_enabled = 1'b1;
  int unsigned gap_left     = 0;
  int unsigned insert_pct   = 35;
  int unsigned quiet_cycles = 0;
  int unsigned error_count  = 0;

  linear_probe_hash_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_index_o(slot_index_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // linear probe over the shadow table, updating it on a successful insert
  function automatic outcome_t probe_table(input logic op, input logic [KEY_W-1:0] key);
    outcome_t    res;
    int unsigned span;
    int unsigned pos;
    bit          hit;
    span = shadow_size;
    if (span == 0) span = 1;
    if (span > DEPTH) span = DEPTH;
    pos = key % span;
    hit = 1'b0;
    res.slot = '0;
    res.status = (op == CMD_INSERT) ? ST_FULL : ST_MISSING;
    for (int unsigned n = 0; n < span && !hit; n++) begin
      if (!slot_used[pos]) begin
        // an empty slot ends both insert and search
        if (op == CMD_INSERT) begin
          slot_used[pos] = 1'b1;
          slot_key[pos]  = key;
          res.status     = ST_INSERTED;
          res.slot       = pos[IDX_W-1:0];
        end
        hit = 1'b1;
      end else if (op == CMD_SEARCH && slot_key[pos] == key) begin
        res.status = ST_FOUND;
        res.slot   = pos[IDX_W-1:0];
        hit        = 1'b1;
      end
      pos = (pos + 1) % span;
    end
    return res;
  endfunction

  // random request: searches lean on keys already inserted, small keys force collisions
  function automatic request_t make_request();
    request_t    r;
    int unsigned pick;
    r.op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_SEARCH;
    pick = $urandom_range(0, 99);
    if (inserted_keys.size() != 0 && pick < ((r.op == CMD_SEARCH) ? 55 : 10))
      r.key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    else if (pick < 80)
      r.key = KEY_W'($urandom_range(0, 63));
    else
      r.key = KEY_W'($urandom);
    if (r.op == CMD_INSERT) inserted_keys.push_back(r.key);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic queue_request(input logic op, input logic [KEY_W-1:0] key);
    request_t r;
    r.op  = op;
    r.key = key;
    request_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  // size register is only written once every request has completed
  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // request driver: changes on the falling edge, idles in short bursts
  always @(negedge clk_i) begin : driver
    logic drive_req;
    drive_req = 1'b0;
    if (req_taken) begin
      request_q.delete(0);
      req_taken = 1'b0;
    end
    if (gap_left != 0) begin
      gap_left--;
    end else if (request_q.size() != 0) begin
      if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 7);
      end else begin
        drive_req = 1'b1;
      end
    end
    start <= drive_req;
    if (drive_req) begin
      cmd_i <= request_q[0].op;
      key_i <= request_q[0].key;
    end
  end

  // monitor: predicts on each accepted request, checks each result, watches for a hang
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    bit       progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_size = cfg_data_i;
        progress    = 1'b1;
      end
      if (start && !busy) begin
        outcome_q.push_back(probe_table(cmd_i, key_i));
        req_taken = 1'b1;
        progress  = 1'b1;
      end
      if (done_o) begin
        progress = 1'b1;
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result status %0d slot %0d with no request pending",
                                    status_o, slot_index_o));
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (slot_index_o !== want.slot)
            report_mismatch($sformatf("slot_index %0d, expected %0d", slot_index_o, want.slot));
        end
      end
    end
    quiet_cycles = progress ? 0 : quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];
    phase_sizes = '{5'd2, 5'd0, 5'd5, 5'd9, 5'd1, 5'd12, 5'd31, 5'd7, 5'd17, 5'd16,
                    5'd4, 5'd24, 5'd16};

    // reset
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset size, wraparound from the top slot, duplicates, empty-slot stop
    queue_request(CMD_SEARCH, '0);
    queue_request(CMD_INSERT, KEY_MAX);
    queue_request(CMD_INSERT, 31'd31);
    queue_request(CMD_SEARCH, 31'd31);
    queue_request(CMD_SEARCH, 31'd47);
    queue_request(CMD_INSERT, 31'd31);
    queue_request(CMD_SEARCH, 31'd31);
    queue_request(CMD_INSERT, '0);
    queue_request(CMD_SEARCH, KEY_MAX);

    // size zero behaves as one: full table and a one-slot lap
    write_table_size(5'd0);
    queue_request(CMD_INSERT, 31'd5);
    queue_request(CMD_SEARCH, 31'd31);
    queue_request(CMD_SEARCH, 31'd7);

    // size above the depth is clamped
    write_table_size(5'd31);
    queue_request(CMD_SEARCH, '0);
    queue_request(CMD_INSERT, 31'h4000_0000);

    // shrunk size hides upper slots, full lap on a small table
    write_table_size(5'd3);
    queue_request(CMD_INSERT, 31'd2);
    queue_request(CMD_SEARCH, 31'h4000_0000);
    queue_request(CMD_SEARCH, '0);

    // random phases over a range of sizes, no idling in the last one
    for (int unsigned i = 0; i < NUM_PHASES; i++) begin
      write_table_size(phase_sizes[i]);
      insert_pct   = (i < 5) ? 35 : 15;
      gaps_enabled = (i != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) request_q.push_back(make_request());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
